[design/spr_pkg.sv]
// Shared types and constants for the stream pattern replace unit.
// No dependencies; every other design file imports this package.
package spr_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned JOB_BYTES = 8;
  localparam int unsigned POS_W     = $clog2(JOB_BYTES);
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned ADDR_W    = 5;

  // Configuration as seen by the front end.
  typedef struct packed {
    logic [DATA_W-1:0] pattern;
    logic [LEN_W-1:0]  plen;
    logic [DATA_W-1:0] replacement;
    logic [LEN_W-1:0]  rlen;
  } cfg_t;

  // One burst of output words produced by one accepted input word.
  // A burst with cnt zero and last set is a bare end marker.
  typedef struct packed {
    logic [JOB_BYTES*BYTE_W-1:0] bytes;
    logic [LEN_W-1:0]            cnt;
    logic                        last;
  } job_t;

endpackage

[design/spr_in_if.sv]
// Input stream channel: valid/ready handshake carrying one text byte.
// Depends on spr_pkg.
interface spr_in_if;
  import spr_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] char_in;
  logic              last_in;

  modport source(output valid, char_in, last_in, input ready);
  modport sink(input valid, char_in, last_in, output ready);
endinterface

[design/spr_out_if.sv]
// Output stream channel: valid/ready handshake carrying one result byte.
// Depends on spr_pkg.
interface spr_out_if;
  import spr_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] char_out;
  logic              has_char;
  logic              last_out;

  modport source(output valid, char_out, has_char, last_out, input ready);
  modport sink(input valid, char_out, has_char, last_out, output ready);
endinterface

[design/stream_pattern_replace_unit.sv]
// Top level of the stream pattern replace unit: register file and wiring.
// Depends on spr_pkg, spr_in_if, spr_out_if, spr_front, spr_queue, spr_back.
//
// The unit takes a text one byte per word on in_i, the final byte flagged by
// last_in, and writes the text to out_o with every leftmost non-overlapping
// occurrence of the pattern replaced by the replacement. An empty replacement
// deletes the matches. A text whose end leaves nothing to send closes with a
// bare end marker (has_char low, last_out high).
// The APB port holds pattern, pattern length, replacement and replacement
// length at byte addresses 0, 8, 16 and 24. Writing the pattern length drops
// the bytes pending in the window; the user is to write registers between
// texts, which the unit itself does not enforce. The first result of an
// input word passes through the burst queue and then the output register.
// Throughput: one input word per cycle while the burst queue has room; the
// back end sends one output word per cycle while the receiver is ready, so
// a word that causes k results holds the back end for k output words and
// the queue of QUEUE_DEPTH bursts absorbs the difference.
// When the receiver stalls, the output register holds its word and the
// queue fills; in_i.ready drops only once the queue is full.
// Reset empties the window and the queue and loads pattern length 1 with all
// other registers zero.
module stream_pattern_replace_unit #(
  parameter int unsigned PATTERN_MAX = 8,
  parameter int unsigned REPLACE_MAX = 8,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  spr_in_if.sink                     in_i,
  spr_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spr_pkg::ADDR_W-1:0] paddr,
  input  logic [spr_pkg::DATA_W-1:0] pwdata,
  output logic [spr_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import spr_pkg::*;

  typedef enum logic [1:0] {
    REG_PATTERN     = 2'd0,
    REG_PATTERN_LEN = 2'd1,
    REG_REPLACEMENT = 2'd2,
    REG_REPLACE_LEN = 2'd3
  } reg_idx_e;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e reg_idx;
  logic     wr_en, cfg_clear;
  logic     push, q_full, pop, head_valid;
  job_t     job, head;

  // Registers sit on 8-byte boundaries; the low address bits are ignored.
  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:3]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d     = cfg_q;
    cfg_clear = 1'b0;
    if (wr_en) begin
      unique case (reg_idx)
        REG_PATTERN:     cfg_d.pattern = pwdata;
        REG_PATTERN_LEN: begin
          cfg_d.plen = pwdata[LEN_W-1:0];
          cfg_clear  = 1'b1;
        end
        REG_REPLACEMENT: cfg_d.replacement = pwdata;
        REG_REPLACE_LEN: cfg_d.rlen = pwdata[LEN_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PATTERN:     prdata = cfg_q.pattern;
      REG_PATTERN_LEN: prdata = DATA_W'(cfg_q.plen);
      REG_REPLACEMENT: prdata = cfg_q.replacement;
      REG_REPLACE_LEN: prdata = DATA_W'(cfg_q.rlen);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern     <= '0;
      cfg_q.plen        <= LEN_W'(1);
      cfg_q.replacement <= '0;
      cfg_q.rlen        <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  spr_front #(
    .PATTERN_MAX(PATTERN_MAX),
    .REPLACE_MAX(REPLACE_MAX)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_i      (cfg_q),
    .cfg_clear_i(cfg_clear),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (job)
  );

  spr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .job_i       (job),
    .full_o      (q_full),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  spr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

[design/spr_front.sv]
// Front end: holds the match window, compares it against the pattern, pushes a
// burst when a word yields bytes or ends text. Depends on spr_pkg and spr_in_if.
module spr_front #(
  parameter int unsigned PATTERN_MAX = 8,
  parameter int unsigned REPLACE_MAX = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  spr_in_if.sink        in_i,
  input  spr_pkg::cfg_t cfg_i,
  input  logic          cfg_clear_i,
  input  logic          q_full_i,
  output logic          push_o,
  output spr_pkg::job_t job_o
);
  import spr_pkg::*;

  localparam int unsigned CNT_W = $clog2(PATTERN_MAX + 1);

  logic [BYTE_W-1:0] win_q     [PATTERN_MAX];
  logic [BYTE_W-1:0] win_d     [PATTERN_MAX];
  logic [BYTE_W-1:0] win_new   [PATTERN_MAX];
  logic [BYTE_W-1:0] win_shift [PATTERN_MAX];
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [LEN_W-1:0]  plen_eff, rlen_eff, cnt_inc;
  logic              accept, full, match;

  assign accept     = in_i.valid && in_i.ready;
  assign in_i.ready = !q_full_i;

  always_comb begin
    if (cfg_i.plen == '0) begin
      plen_eff = LEN_W'(1);
    end else if (cfg_i.plen > LEN_W'(PATTERN_MAX)) begin
      plen_eff = LEN_W'(PATTERN_MAX);
    end else begin
      plen_eff = cfg_i.plen;
    end
    if (cfg_i.rlen > LEN_W'(REPLACE_MAX)) begin
      rlen_eff = LEN_W'(REPLACE_MAX);
    end else begin
      rlen_eff = cfg_i.rlen;
    end
  end

  assign cnt_inc = LEN_W'(cnt_q) + LEN_W'(1);
  assign full    = (cnt_inc == plen_eff);

  // The new byte lands at the first free window slot.
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      win_new[i] = (LEN_W'(cnt_q) == LEN_W'(i)) ? in_i.char_in : win_q[i];
    end
    for (int i = 0; i < PATTERN_MAX - 1; i++) begin
      win_shift[i] = win_new[i + 1];
    end
    win_shift[PATTERN_MAX-1] = win_new[PATTERN_MAX-1];
  end

  // Parallel compare of every active window slot against its pattern byte.
  always_comb begin
    match = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if ((LEN_W'(i) < plen_eff) &&
          (win_new[i] != cfg_i.pattern[BYTE_W*i +: BYTE_W])) begin
        match = 1'b0;
      end
    end
  end

  // A burst either replaces a match, releases the oldest window byte, or
  // flushes the whole window at the end of the text.
  always_comb begin
    job_o.bytes = '0;
    job_o.last  = in_i.last_in;
    if (full && match) begin
      job_o.bytes = cfg_i.replacement;
      job_o.cnt   = rlen_eff;
    end else begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        job_o.bytes[BYTE_W*k +: BYTE_W] = win_new[k];
      end
      if (full) begin
        job_o.cnt = in_i.last_in ? plen_eff : LEN_W'(1);
      end else begin
        job_o.cnt = in_i.last_in ? cnt_inc : LEN_W'(0);
      end
    end
  end

  assign push_o = accept && (in_i.last_in || (job_o.cnt != '0));

  always_comb begin
    cnt_d = cnt_q;
    win_d = win_q;
    if (cfg_clear_i) begin
      cnt_d = '0;
    end else if (accept) begin
      if (in_i.last_in || (full && match)) begin
        cnt_d = '0;
      end else if (full) begin
        cnt_d = CNT_W'(plen_eff - LEN_W'(1));
        win_d = win_shift;
      end else begin
        cnt_d = CNT_W'(cnt_inc);
        win_d = win_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  a_cnt_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LEN_W'(cnt_q) < plen_eff)
    else $error("window count reached the pattern length");

  a_last_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.last_in |=> cnt_q == '0)
    else $error("window not empty after end of text");

endmodule

[design/spr_queue.sv]
// Short burst queue between the front end and the back end.
// Depends on spr_pkg.
module spr_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  spr_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output spr_pkg::job_t head_o
);
  import spr_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == CNT_W'(DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("burst queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("burst queue underflow");

endmodule

[design/spr_back.sv]
// Back end: plays the head burst out one word per cycle, while the receiver
// is ready, into the output register. Depends on spr_pkg and spr_out_if.
module spr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  spr_pkg::job_t head_i,
  output logic          pop_o,
  spr_out_if.source     out_o
);
  import spr_pkg::*;

  logic [POS_W-1:0]  pos_q, pos_d;
  logic              valid_q, valid_d;
  logic [BYTE_W-1:0] char_q, char_d;
  logic              has_q, has_d, last_q, last_d;
  logic              fire, done, bare;

  assign bare  = (head_i.cnt == '0);
  assign done  = bare || ((LEN_W'(pos_q) + LEN_W'(1)) == head_i.cnt);
  assign fire  = head_valid_i && (!valid_q || out_o.ready);
  assign pop_o = fire && done;

  always_comb begin
    pos_d   = pos_q;
    valid_d = valid_q;
    char_d  = char_q;
    has_d   = has_q;
    last_d  = last_q;
    if (fire) begin
      valid_d = 1'b1;
      char_d  = bare ? '0 : head_i.bytes[BYTE_W*pos_q +: BYTE_W];
      has_d   = !bare;
      last_d  = head_i.last && done;
      pos_d   = done ? '0 : pos_q + POS_W'(1);
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    has_q  <= has_d;
    last_q <= last_d;
  end

  assign out_o.valid    = valid_q;
  assign out_o.char_out = char_q;
  assign out_o.has_char = has_q;
  assign out_o.last_out = last_q;

  a_bare_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !has_q |-> last_q && (char_q == '0))
    else $error("bare end marker without last flag");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for stream_pattern_replace_unit: directed texts, then random texts.
// Results are predicted from a local model of the window and its registers, or typed by hand.
// Depends on spr_pkg, spr_in_if, spr_out_if and the unit itself.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import spr_pkg::*;

  localparam int unsigned PAT_MAX       = 8;
  localparam int unsigned REP_MAX       = 8;
  localparam int unsigned SETTLE_CYCLES = 16;   // generous against the burst queue and output register
  localparam int unsigned HOLD_CYCLES   = 300;  // long receiver stall for back-pressure
  localparam int unsigned PHASES        = 10;
  localparam int unsigned PHASE_BYTES   = 50;
  localparam int unsigned BURST_MAX     = 16;

  // Register map of the APB port: register n lives at byte address 8*n.
  typedef enum logic [1:0] {
    REG_PATTERN,
    REG_PLEN,
    REG_REPLACE,
    REG_RLEN
  } reg_sel_e;

  // One output word as it appears on out_o.
  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              has;
    logic              last;
  } text_word_t;

  // One row of the directed table: either a register write or one text byte.
  // A typed row carries its single expected word, written out by hand.
  typedef struct {
    logic              is_write;
    reg_sel_e          sel;
    logic [DATA_W-1:0] value;
    logic [BYTE_W-1:0] ch;
    logic              last;
    logic              typed;
    text_word_t        want;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  spr_in_if  in_if ();
  spr_out_if out_if ();

  stream_pattern_replace_unit #(
    .PATTERN_MAX(PAT_MAX),
    .REPLACE_MAX(REP_MAX)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #2 clk_i = ~clk_i;

  // Shadow copy of the registers and of the match window.
  logic [DATA_W-1:0] cfg_pattern;
  logic [LEN_W-1:0]  cfg_plen;
  logic [DATA_W-1:0] cfg_replace;
  logic [LEN_W-1:0]  cfg_rlen;
  logic [BYTE_W-1:0] win [PAT_MAX];
  int unsigned       win_cnt;

  text_word_t  burst [BURST_MAX];  // words caused by the latest accepted byte
  text_word_t  due_words [$];      // words still owed by the unit, oldest first
  stim_row_t   rows [$];

  int unsigned bad_words;
  int unsigned words_seen;
  int unsigned bytes_sent;
  int unsigned texts_sent;
  int unsigned matches_seen;
  int unsigned settings_used;
  logic        steady;   // when set neither side inserts gaps
  logic        hold_on;  // receiver forced to stall
  event        hold_start;

  // A pattern length of zero acts as one, anything above the maximum saturates.
  function automatic int unsigned pat_len_eff();
    int unsigned n;
    n = cfg_plen;
    if (n == 0) n = 1;
    if (n > PAT_MAX) n = PAT_MAX;
    return n;
  endfunction

  function automatic int unsigned rep_len_eff();
    int unsigned n;
    n = cfg_rlen;
    if (n > REP_MAX) n = REP_MAX;
    return n;
  endfunction

  // Push one byte into the window and work out the words it releases. A full
  // window equal to the pattern turns into the replacement and empties; any
  // other full window gives up its oldest byte. The last byte of a text
  // flushes the window, and a text end with nothing left gives a bare marker.
  function automatic int unsigned replace_step(input logic [BYTE_W-1:0] ch, input logic last);
    int unsigned plen;
    int unsigned n;
    int unsigned i;
    logic        hit;
    plen = pat_len_eff();
    n = 0;
    win[win_cnt] = ch;
    win_cnt++;
    if (win_cnt == plen) begin
      hit = 1'b1;
      for (i = 0; i < plen; i++) begin
        if (win[i] != cfg_pattern[8*i +: 8]) hit = 1'b0;
      end
      if (hit) begin
        for (i = 0; i < rep_len_eff(); i++) begin
          burst[n] = '{ch: cfg_replace[8*i +: 8], has: 1'b1, last: 1'b0};
          n++;
        end
        win_cnt = 0;
        matches_seen++;
      end else begin
        burst[n] = '{ch: win[0], has: 1'b1, last: 1'b0};
        n++;
        for (i = 1; i < plen; i++) win[i-1] = win[i];
        win_cnt--;
      end
    end
    if (last) begin
      for (i = 0; i < win_cnt; i++) begin
        burst[n] = '{ch: win[i], has: 1'b1, last: 1'b0};
        n++;
      end
      win_cnt = 0;
      if (n == 0) begin
        burst[0] = '{ch: '0, has: 1'b0, last: 1'b0};
        n = 1;
      end
      burst[n-1].last = 1'b1;
    end
    return n;
  endfunction

  // Each side idles at random, about 16 percent of the time, unless the run is steady.
  function automatic bit take_gap();
    return !steady && ($urandom_range(99) < 16);
  endfunction

  // With narrow set, pattern bytes from a two-letter alphabet give plenty of self-overlap; else they are random.
  function automatic logic [DATA_W-1:0] rand_pattern(input bit narrow);
    logic [DATA_W-1:0] p;
    int unsigned       i;
    for (i = 0; i < 8; i++) p[8*i +: 8] = narrow ? 8'(8'h61 + $urandom_range(1)) : 8'($urandom);
    return p;
  endfunction

  function automatic stim_row_t text_row(input logic [BYTE_W-1:0] ch, input logic last,
                                         input logic typed, input text_word_t want);
    return '{is_write: 1'b0, sel: REG_PATTERN, value: '0, ch: ch, last: last,
             typed: typed, want: want};
  endfunction

  function automatic stim_row_t write_row(input reg_sel_e sel, input logic [DATA_W-1:0] value);
    return '{is_write: 1'b1, sel: sel, value: value, ch: '0, last: 1'b0,
             typed: 1'b0, want: '0};
  endfunction

  // APB write: setup phase, access phase, then the bus released.
  // The shadow registers follow, and a new pattern length empties the window.
  task automatic write_reg(input reg_sel_e sel, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(8 * sel);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    case (sel)
      REG_PATTERN: cfg_pattern = value;
      REG_PLEN: begin
        cfg_plen = value[LEN_W-1:0];
        win_cnt  = 0;
      end
      REG_REPLACE: cfg_replace = value;
      REG_RLEN:    cfg_rlen    = value[LEN_W-1:0];
      default: ;
    endcase
  endtask

  // Offer one byte, wait for the handshake and book the words it causes.
  // valid is left high so that back-to-back bytes follow without a gap.
  task automatic send_byte(input logic [BYTE_W-1:0] ch, input logic last,
                           input logic typed, input text_word_t want);
    int unsigned n;
    int unsigned i;
    while (take_gap()) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.char_in <= ch;
    in_if.last_in <= last;
    do @(posedge clk_i); while (!in_if.ready);
    n = replace_step(ch, last);
    if (typed) due_words.push_back(want);
    else for (i = 0; i < n; i++) due_words.push_back(burst[i]);
    bytes_sent++;
    if (last) texts_sent++;
  endtask

  // Bring the unit to rest: no byte offered, every owed word received, and a
  // few more cycles for a byte that is still in the window pipeline.
  task automatic settle();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (due_words.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Build one text mostly from whole or partial copies of the pattern, mixed
  // with pattern bytes at random places and fully random bytes.
  task automatic send_text();
    logic [BYTE_W-1:0] text [$];
    int unsigned       len;
    int unsigned       plen;
    int unsigned       k;
    int unsigned       j;
    int unsigned       r;
    plen = pat_len_eff();
    len  = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    while (text.size() < len) begin
      r = $urandom_range(99);
      if (r < 30) k = plen;
      else if (r < 45) k = $urandom_range(1, plen);
      else k = 0;
      for (j = 0; j < k; j++) text.push_back(cfg_pattern[8*j +: 8]);
      if (k == 0) begin
        if (r < 75) text.push_back(cfg_pattern[8*$urandom_range(plen - 1) +: 8]);
        else text.push_back(8'($urandom));
      end
    end
    while (text.size() > len) void'(text.pop_back());
    for (j = 0; j < text.size(); j++) send_byte(text[j], j == text.size() - 1, 1'b0, '0);
  endtask

  // Receiver: checks every accepted word against the oldest owed word and
  // drives ready with random gaps, or holds it low during a forced stall.
  always @(posedge clk_i) begin
    text_word_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      words_seen++;
      if (due_words.size() == 0) begin
        bad_words++;
        $display("%0t: word with none expected: char %02h has %0b last %0b", $time,
                 out_if.char_out, out_if.has_char, out_if.last_out);
      end else begin
        want = due_words.pop_front();
        if (out_if.char_out !== want.ch || out_if.has_char !== want.has ||
            out_if.last_out !== want.last) begin
          bad_words++;
          $display("%0t: expected char %02h has %0b last %0b, got char %02h has %0b last %0b",
                   $time, want.ch, want.has, want.last,
                   out_if.char_out, out_if.has_char, out_if.last_out);
        end
      end
    end
    out_if.ready <= !hold_on && !take_gap();
  end

  // The long stall is counted here, apart from the receiver, while the
  // sender keeps offering bytes so that the burst queue fills.
  initial begin
    forever begin
      @(hold_start);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_on <= 1'b0;
    end
  end

  // Hard stop for a hung handshake.
  initial begin
    #2_000_000;
    $display("[stream_pattern_replace_unit] ERROR");
    $finish;
  end

  initial begin
    logic [3:0]  plen_sel;
    logic [3:0]  rlen_sel;
    int unsigned p;
    int unsigned start;

    // Every input at a known value from time zero.
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_if.valid   = 1'b0;
    in_if.char_in = '0;
    in_if.last_in = 1'b0;
    out_if.ready  = 1'b0;
    hold_on       = 1'b0;
    steady        = 1'b0;
    bad_words     = 0;
    words_seen    = 0;
    bytes_sent    = 0;
    texts_sent    = 0;
    matches_seen  = 0;
    settings_used = 1;
    cfg_pattern   = '0;
    cfg_plen      = 4'd1;
    cfg_replace   = '0;
    cfg_rlen      = '0;
    win_cnt       = 0;
    foreach (win[i]) win[i] = '0;

    // Directed table. After reset the pattern is one zero byte and the
    // replacement is empty, so a zero byte vanishes into a bare end marker.
    rows.push_back(text_row(8'h00, 1'b1, 1'b1, '{ch: 8'h00, has: 1'b0, last: 1'b1}));
    rows.push_back(text_row(8'hFF, 1'b1, 1'b1, '{ch: 8'hFF, has: 1'b1, last: 1'b1}));
    // Pattern length zero acts as one; replacement length 15 saturates to 8.
    rows.push_back(write_row(REG_PLEN, 64'd0));
    rows.push_back(write_row(REG_PATTERN, 64'hAA));
    rows.push_back(write_row(REG_REPLACE, 64'h0123_4567_89AB_CDEF));
    rows.push_back(write_row(REG_RLEN, 64'd15));
    rows.push_back(text_row(8'hAA, 1'b1, 1'b0, '0));
    rows.push_back(text_row(8'h55, 1'b1, 1'b1, '{ch: 8'h55, has: 1'b1, last: 1'b1}));
    // Longest pattern of all-ones bytes, length 15 saturating to 8, deleted.
    rows.push_back(write_row(REG_PATTERN, '1));
    rows.push_back(write_row(REG_PLEN, 64'd15));
    rows.push_back(write_row(REG_RLEN, 64'd0));
    for (int i = 0; i < 7; i++) rows.push_back(text_row(8'hFF, 1'b0, 1'b0, '0));
    rows.push_back(text_row(8'hFF, 1'b1, 1'b1, '{ch: 8'h00, has: 1'b0, last: 1'b1}));
    // A partial match cut off by the end of the text is flushed as is.
    rows.push_back(text_row(8'hFF, 1'b0, 1'b0, '0));
    rows.push_back(text_row(8'hFF, 1'b0, 1'b0, '0));
    rows.push_back(text_row(8'h00, 1'b1, 1'b0, '0));
    // "aabcx" with pattern "abc" and replacement "X".
    rows.push_back(write_row(REG_PATTERN, 64'h63_6261));
    rows.push_back(write_row(REG_PLEN, 64'd3));
    rows.push_back(write_row(REG_REPLACE, 64'h58));
    rows.push_back(write_row(REG_RLEN, 64'd1));
    rows.push_back(text_row(8'h61, 1'b0, 1'b0, '0));
    rows.push_back(text_row(8'h61, 1'b0, 1'b0, '0));
    rows.push_back(text_row(8'h62, 1'b0, 1'b0, '0));
    rows.push_back(text_row(8'h63, 1'b0, 1'b0, '0));
    rows.push_back(text_row(8'h78, 1'b1, 1'b0, '0));
    rows.push_back(text_row(8'h61, 1'b1, 1'b1, '{ch: 8'h61, has: 1'b1, last: 1'b1}));
    // Rewriting the pattern length mid-text drops "ab", so "c" stands alone.
    rows.push_back(text_row(8'h61, 1'b0, 1'b0, '0));
    rows.push_back(text_row(8'h62, 1'b0, 1'b0, '0));
    rows.push_back(write_row(REG_PLEN, 64'd3));
    rows.push_back(text_row(8'h63, 1'b1, 1'b1, '{ch: 8'h63, has: 1'b1, last: 1'b1}));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[r]) begin
      if (rows[r].is_write) begin
        settle();
        write_reg(rows[r].sel, rows[r].value);
        settings_used++;
      end else begin
        send_byte(rows[r].ch, rows[r].last, rows[r].typed, rows[r].want);
      end
    end

    // Random phases, one register setting each. The first four pin the
    // length extremes; phase 0 runs under a long receiver stall with every
    // match expanding to eight words, and phase 3 runs without any gaps.
    for (p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: begin
          plen_sel = 4'd1;
          rlen_sel = 4'd8;
        end
        1: begin
          plen_sel = 4'd8;
          rlen_sel = 4'd0;
        end
        2: begin
          plen_sel = 4'd0;
          rlen_sel = 4'd15;
        end
        3: begin
          plen_sel = 4'd15;
          rlen_sel = 4'd1;
        end
        default: begin
          plen_sel = 4'($urandom_range(15));
          rlen_sel = 4'($urandom_range(15));
        end
      endcase
      write_reg(REG_PATTERN, rand_pattern($urandom_range(1)));
      write_reg(REG_PLEN, 64'(plen_sel));
      write_reg(REG_REPLACE, {$urandom, $urandom});
      write_reg(REG_RLEN, 64'(rlen_sel));
      settings_used++;
      steady <= (p == 3);
      if (p == 0) -> hold_start;
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) send_text();
    end

    settle();
    $display("Covered %0d texts, %0d bytes, %0d register settings, %0d pattern matches.",
             texts_sent, bytes_sent, settings_used, matches_seen);
    $display("Checked %0d output words, %0d of them wrong.", words_seen, bad_words);
    if (bad_words == 0) begin
      $display("[stream_pattern_replace_unit] OK");
    end else begin
      $display("[stream_pattern_replace_unit] ERROR");
    end
    $finish;
  end

endmodule
